// ===== hw/rtl/lwbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lwbc_pkg: shared types and constants
// Transaction payloads, operation and result codes, default sizes.
// ----------------------------------------------------------------------------
package lwbc_pkg;

  localparam int DefEntries   = 16;
  localparam int DefKeyBits   = 32;
  localparam int DefValueBits = 32;
  localparam int CapBits      = 5;
  localparam logic [CapBits-1:0] CapReset = 5'd16;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_GET   = 2'd1,
    OP_FILL  = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_DONE      = 3'd0,
    KIND_READ      = 3'd1,
    KIND_FETCH     = 3'd2,
    KIND_WRITEBACK = 3'd3,
    KIND_NOT_FOUND = 3'd4
  } kind_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
    logic [31:0] value;
    logic        found;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] out_key;
    logic [31:0] out_value;
    logic        last;
  } rsp_t;

  // Per-cell control issued by the sequencer.
  typedef struct packed {
    logic shift;      // take the upper neighbor's entry
    logic load;       // take the broadcast entry
    logic clr_dirty;  // clear the dirty mark
  } cell_cmd_t;

endpackage

// ===== hw/rtl/lwbc_cell.sv =====
// ----------------------------------------------------------------------------
// lwbc_cell: one entry of the recency chain
// Holds key, value and dirty mark; compares its key against the lookup key.
// ----------------------------------------------------------------------------
module lwbc_cell
  import lwbc_pkg::*;
#(
  parameter int KEY_BITS   = DefKeyBits,
  parameter int VALUE_BITS = DefValueBits
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_cmd_t             cmd,
  input  logic [KEY_BITS-1:0]   up_key,
  input  logic [VALUE_BITS-1:0] up_value,
  input  logic                  up_dirty,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  in_dirty,
  input  logic [KEY_BITS-1:0]   cmp_key,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] value,
  output logic                  dirty,
  output logic                  match
);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key   <= in_key;
      value <= in_value;
    end else if (cmd.shift) begin
      key   <= up_key;
      value <= up_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= 1'b0;
    end else if (cmd.load) begin
      dirty <= in_dirty;
    end else if (cmd.shift) begin
      dirty <= up_dirty;
    end else if (cmd.clr_dirty) begin
      dirty <= 1'b0;
    end
  end

  assign match = (key == cmp_key);

endmodule

// ===== hw/rtl/lru_write_back_cache.sv =====
// ----------------------------------------------------------------------------
// lru_write_back_cache: fully associative write-back cache with LRU order
// A chain of entry cells kept in recency order, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Usage.
// A command transaction (set, get, fill or flush) is taken at a clock edge
// where start is high and busy is low. Busy stays high until the last result
// of that command has been issued. Each result is shown on result for exactly
// one cycle with result_valid high; result.last marks the final one. The
// receiver cannot stall the block, so results are never held back. The user must
// write the capacity register (cfg_we/cfg_data) while idle; the block does not check.
//
// Sequence. A lookup accepts the command, compares the key against every cell,
// then updates the chain. Each eviction of a least recent entry adds an evict
// step, and an insertion adds an insert step. A flush walks the chain one cell
// a cycle from least to most recent and then issues its done result. The
// chain moves by at most one neighbor step per cycle.
//
// Cells are ordered by recency: cell 0 is least recent, cell occupancy-1 the
// most recent. Reset empties the cache, clears all dirty marks and sets the
// capacity to sixteen; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_write_back_cache
  import lwbc_pkg::*;
#(
  parameter int ENTRIES    = DefEntries,
  parameter int KEY_BITS   = DefKeyBits,
  parameter int VALUE_BITS = DefValueBits
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cmd_t               cmd,
  output logic               busy,
  output logic               result_valid,
  output rsp_t               result,
  input  logic               cfg_we,
  input  logic [CapBits-1:0] cfg_data
);

  localparam int OW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_EVICT = 6'b001000,
    S_INS   = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t state, state_next;

  // Captured command.
  op_t                   op;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;
  logic                  req_found;

  logic [CapBits-1:0] entries_in_use;
  logic [OW-1:0]      occ, occ_next;
  logic [OW-1:0]      idx, idx_next;
  logic [ENTRIES-1:0] hit_vec;

  // Cell outputs.
  logic [KEY_BITS-1:0]   c_key   [ENTRIES];
  logic [VALUE_BITS-1:0] c_value [ENTRIES];
  logic                  c_dirty [ENTRIES];
  logic [ENTRIES-1:0]    c_match;
  cell_cmd_t             c_cmd   [ENTRIES];

  // Broadcast entry.
  logic [KEY_BITS-1:0]   b_key;
  logic [VALUE_BITS-1:0] b_value;
  logic                  b_dirty;

  // Emission for the next cycle.
  logic        emit, em_last;
  kind_t       em_kind;
  logic [31:0] em_key, em_value;

  // Saturated capacity and occupancy compared in a common width.
  logic [7:0] cap8, occ8;
  assign cap8 = ({3'b0, entries_in_use} > 8'(ENTRIES)) ? 8'(ENTRIES) : {3'b0, entries_in_use};
  assign occ8 = 8'(occ);

  logic need_evict, need_evict_after;
  assign need_evict       = (occ8 != 8'd0) && (occ8 >= cap8);
  assign need_evict_after = (occ8 > 8'd1) && ((occ8 - 8'd1) >= cap8);

  // The hit cell's contents, gathered from the one-hot hit vector.
  logic [KEY_BITS-1:0]   h_key;
  logic [VALUE_BITS-1:0] h_value;
  logic                  h_dirty;
  logic                  any_hit;
  always_comb begin
    h_key   = '0;
    h_value = '0;
    h_dirty = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) begin
        h_key   = h_key | c_key[i];
        h_value = h_value | c_value[i];
        h_dirty = h_dirty | c_dirty[i];
      end
    end
  end
  assign any_hit = |hit_vec;

  // A hit is touched when a set or get hits, or a fill that was found hits, while the capacity is nonzero.
  logic touch;
  assign touch = (state == S_EXEC) && (cap8 != 8'd0) && any_hit &&
                 ((op == OP_SET) || (op == OP_GET) || ((op == OP_FILL) && req_found));

  always_comb begin
    if (state == S_INS) begin
      b_key   = req_key;
      b_value = req_value;
      b_dirty = (op == OP_SET);
    end else begin
      b_key   = h_key;
      b_value = (op == OP_GET) ? h_value : req_value;
      b_dirty = (op == OP_SET) ? 1'b1 : ((op == OP_GET) ? h_dirty : 1'b0);
    end
  end

  // Chain of cells. Each cell looks only at its upper neighbor and the broadcast entry.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    localparam logic [ENTRIES-1:0] LowMask = ENTRIES'((64'd2 << i) - 64'd1);
    logic                  ge_hit;
    logic [KEY_BITS-1:0]   u_key;
    logic [VALUE_BITS-1:0] u_value;
    logic                  u_dirty;

    assign ge_hit = |(hit_vec & LowMask);

    if (i < ENTRIES - 1) begin : g_up
      assign u_key   = c_key[i+1];
      assign u_value = c_value[i+1];
      assign u_dirty = c_dirty[i+1];
    end else begin : g_top
      assign u_key   = '0;
      assign u_value = '0;
      assign u_dirty = 1'b0;
    end

    always_comb begin
      c_cmd[i] = '0;
      if (touch) begin
        c_cmd[i].shift = ge_hit && (OW'(i) < occ - OW'(1));
        c_cmd[i].load  = (OW'(i) == occ - OW'(1));
      end else if (state == S_EVICT) begin
        c_cmd[i].shift = 1'b1;
      end else if (state == S_INS) begin
        c_cmd[i].load = (OW'(i) == occ);
      end else if (state == S_FLUSH) begin
        c_cmd[i].clr_dirty = (OW'(i) == idx) && (idx < occ);
      end
    end

    lwbc_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (c_cmd[i]),
      .up_key  (u_key),
      .up_value(u_value),
      .up_dirty(u_dirty),
      .in_key  (b_key),
      .in_value(b_value),
      .in_dirty(b_dirty),
      .cmp_key (req_key),
      .key     (c_key[i]),
      .value   (c_value[i]),
      .dirty   (c_dirty[i]),
      .match   (c_match[i])
    );
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    occ_next   = occ;
    idx_next   = idx;
    emit       = 1'b0;
    em_last    = 1'b0;
    em_kind    = KIND_DONE;
    em_key     = '0;
    em_value   = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
        emit       = 1'b1;
        em_last    = 1'b1;
        em_key     = 32'(req_key);
        if (op == OP_FLUSH) begin
          emit       = 1'b0;
          idx_next   = '0;
          state_next = S_FLUSH;
        end else if (cap8 == 8'd0) begin
          unique case (op)
            OP_SET: begin
              em_kind  = KIND_WRITEBACK;
              em_value = 32'(req_value);
            end
            OP_GET: em_kind = KIND_FETCH;
            default: begin
              if (req_found) begin
                em_kind  = KIND_READ;
                em_value = 32'(req_value);
              end else begin
                em_kind = KIND_NOT_FOUND;
              end
            end
          endcase
        end else if (op == OP_GET) begin
          if (any_hit) begin
            em_kind  = KIND_READ;
            em_value = 32'(h_value);
          end else begin
            em_kind = KIND_FETCH;
          end
        end else if ((op == OP_FILL) && !req_found) begin
          em_kind = KIND_NOT_FOUND;
        end else if (any_hit) begin
          if (op == OP_SET) begin
            em_kind = KIND_DONE;
            em_key  = '0;
          end else begin
            em_kind  = KIND_READ;
            em_value = 32'(req_value);
          end
        end else begin
          emit       = 1'b0;
          state_next = need_evict ? S_EVICT : S_INS;
        end
      end
      S_EVICT: begin
        occ_next   = occ - OW'(1);
        state_next = need_evict_after ? S_EVICT : S_INS;
        if (c_dirty[0]) begin
          emit     = 1'b1;
          em_kind  = KIND_WRITEBACK;
          em_key   = 32'(c_key[0]);
          em_value = 32'(c_value[0]);
        end
      end
      S_INS: begin
        occ_next   = occ + OW'(1);
        state_next = S_IDLE;
        emit       = 1'b1;
        em_last    = 1'b1;
        if (op == OP_SET) begin
          em_kind = KIND_DONE;
        end else begin
          em_kind  = KIND_READ;
          em_key   = 32'(req_key);
          em_value = 32'(req_value);
        end
      end
      S_FLUSH: begin
        if (idx < occ) begin
          idx_next = idx + OW'(1);
          if (c_dirty[idx[IW-1:0]]) begin
            emit     = 1'b1;
            em_kind  = KIND_WRITEBACK;
            em_key   = 32'(c_key[idx[IW-1:0]]);
            em_value = 32'(c_value[idx[IW-1:0]]);
          end
        end else begin
          emit       = 1'b1;
          em_last    = 1'b1;
          em_kind    = KIND_DONE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      occ            <= '0;
      idx            <= '0;
      entries_in_use <= CapReset;
      result_valid   <= 1'b0;
    end else begin
      state        <= state_next;
      occ          <= occ_next;
      idx          <= idx_next;
      result_valid <= emit;
      if (cfg_we) begin
        entries_in_use <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      op        <= op_t'(cmd.operation);
      req_key   <= KEY_BITS'(cmd.key);
      req_value <= VALUE_BITS'(cmd.value);
      req_found <= cmd.found;
    end
    if (state == S_LOOK) begin
      for (int i = 0; i < ENTRIES; i++) begin
        hit_vec[i] <= c_match[i] && (OW'(i) < occ);
      end
    end
    result.kind      <= em_kind;
    result.out_key   <= em_key;
    result.out_value <= em_value;
    result.last      <= em_last;
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== hw/rtl/lwbc_checker.sv =====
// ----------------------------------------------------------------------------
// lwbc_assertions: port-level checks for the cache
// Relates command acceptance, busy and the result strobe over time.
// ----------------------------------------------------------------------------
module lwbc_assertions
  import lwbc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input rsp_t result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted command");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> !busy)
    else $error("still busy when the final result is shown");

  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> busy)
    else $error("idle while more results are due");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !result_valid)
    else $error("result without a command");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.kind == KIND_DONE)) |->
      ((result.out_key == 32'd0) && (result.out_value == 32'd0)))
    else $error("done result carries data");

endmodule

bind lru_write_back_cache lwbc_assertions u_lwbc_assertions (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .result_valid(result_valid),
  .result      (result)
);
